// ===== rtl/shared_buffer_refcount_conflict_tracker_unit_assert.svh =====
// assertion macros shared by the tracker rtl
`ifndef SHARED_BUFFER_REFCOUNT_CONFLICT_TRACKER_UNIT_ASSERT_SVH
`define SHARED_BUFFER_REFCOUNT_CONFLICT_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define SBRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbrc assertion failed");

// next-cycle implication
`define SBRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbrc assertion failed");

`endif

// ===== rtl/sbrc_pkg.sv =====
// shared types and constants of the refcount conflict tracker
`default_nettype none

package sbrc_pkg;

    localparam int NET_W      = 6;
    localparam int OWNER_W    = 6;
    localparam int USES_W     = 16;
    localparam int PAIR_OUT_W = 16;
    localparam int CNT_OUT_W  = 7;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NETS_IN_USE   = 1'b0,
        CFG_OWNERS_IN_USE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [NET_W-1:0]   net_index;
        logic               owner_present;
        logic [OWNER_W-1:0] owner_index;
        logic [USES_W-1:0]  removed_uses;
        logic [USES_W-1:0]  added_uses;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            status;
        logic [PAIR_OUT_W-1:0] pair_refcount;
        logic [CNT_OUT_W-1:0]  owner_net_count;
        logic                  owner_in_conflict;
        logic [CNT_OUT_W-1:0]  conflict_total;
        logic                  any_conflict;
        logic [OWNER_W-1:0]    first_conflict_owner;
    } t_out_item;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [NET_W-1:0]   net;
        logic [OWNER_W-1:0] owner;
    } t_store_ctl;

    typedef struct packed {
        logic               set;
        logic               clr;
        logic [OWNER_W-1:0] owner;
    } t_flag_ctl;

endpackage

`default_nettype wire

// ===== rtl/sbrc_if.sv =====
// valid/ready channel interfaces for input and result items
`default_nettype none

interface sbrc_in_if;
    logic                valid;
    logic                ready;
    sbrc_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sbrc_out_if;
    logic                valid;
    logic                ready;
    sbrc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sbrc_store.sv =====
// pair refcount and owner net count memories with post-reset clearing sweep
`default_nettype none

module sbrc_store #(
    parameter int MAX_NETS   = 64,
    parameter int MAX_OWNERS = 64,
    parameter int COUNT_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire sbrc_pkg::t_store_ctl    i_ctl,
    input  wire [COUNT_BITS-1:0]         i_pair_wdata,
    input  wire [$clog2(MAX_NETS+1)-1:0] i_cnt_wdata,
    output logic [COUNT_BITS-1:0]        o_pair_rdata,
    output logic [$clog2(MAX_NETS+1)-1:0] o_cnt_rdata,
    output logic                         o_busy
);

    localparam int PAIR_DEPTH = MAX_NETS * MAX_OWNERS;
    localparam int PAW        = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int OW         = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
    localparam int CNW        = $clog2(MAX_NETS + 1);

    localparam logic [PAW:0] CLR_END   = (PAW+1)'(PAIR_DEPTH);
    localparam logic [PAW:0] OWNER_END = (PAW+1)'(MAX_OWNERS);

    logic [COUNT_BITS-1:0] r_pair_mem [PAIR_DEPTH];
    logic [CNW-1:0]        r_cnt_mem  [MAX_OWNERS];

    logic [PAW:0]          r_clr;
    logic [COUNT_BITS-1:0] r_pair_rdata;
    logic [CNW-1:0]        r_cnt_rdata;
    logic [PAW-1:0]        w_pair_addr;
    logic [OW-1:0]         w_owner_addr;
    logic                  w_busy;

    assign w_pair_addr  = PAW'(int'(i_ctl.net) * MAX_OWNERS + int'(i_ctl.owner));
    assign w_owner_addr = OW'(i_ctl.owner);
    assign w_busy       = (r_clr < CLR_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (w_busy) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_busy) begin
            r_pair_mem[r_clr[PAW-1:0]] <= '0;
        end else if (i_ctl.wr_en) begin
            r_pair_mem[w_pair_addr] <= i_pair_wdata;
        end
        if (i_ctl.rd_en) begin
            r_pair_rdata <= r_pair_mem[w_pair_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_busy) begin
            if (r_clr < OWNER_END) begin
                r_cnt_mem[r_clr[OW-1:0]] <= '0;
            end
        end else if (i_ctl.wr_en) begin
            r_cnt_mem[w_owner_addr] <= i_cnt_wdata;
        end
        if (i_ctl.rd_en) begin
            r_cnt_rdata <= r_cnt_mem[w_owner_addr];
        end
    end

    assign o_pair_rdata = r_pair_rdata;
    assign o_cnt_rdata  = r_cnt_rdata;
    assign o_busy       = w_busy;

endmodule

`default_nettype wire

// ===== rtl/sbrc_conflict.sv =====
// per-owner conflict flags, conflicting owner total and lowest conflicting owner
`default_nettype none
`include "shared_buffer_refcount_conflict_tracker_unit_assert.svh"

module sbrc_conflict #(
    parameter int MAX_OWNERS = 64
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  wire sbrc_pkg::t_flag_ctl                     i_ctl,
    input  wire [sbrc_pkg::OWNER_W-1:0]                  i_sel_owner,
    output logic [$clog2(MAX_OWNERS+1)-1:0]              o_total,
    output logic                                         o_flag,
    output logic [((MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1)-1:0] o_first
);

    localparam int OW = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
    localparam int TW = $clog2(MAX_OWNERS + 1);

    logic [MAX_OWNERS-1:0] r_flags;
    logic [TW-1:0]         r_total;
    logic [OW-1:0]         w_idx;
    logic [OW-1:0]         w_sel;
    logic [OW-1:0]         w_first;

    assign w_idx = OW'(i_ctl.owner);
    assign w_sel = OW'(i_sel_owner);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_total <= '0;
        end else if (i_ctl.set) begin
            r_flags[w_idx] <= 1'b1;
            r_total        <= r_total + 1'b1;
        end else if (i_ctl.clr && (r_total != '0)) begin
            r_flags[w_idx] <= 1'b0;
            r_total        <= r_total - 1'b1;
        end
    end

    // lowest set flag, zero when none
    always_comb begin
        w_first = '0;
        for (int i = MAX_OWNERS - 1; i >= 0; i--) begin
            if (r_flags[i]) begin
                w_first = OW'(i);
            end
        end
    end

    assign o_total = r_total;
    assign o_flag  = r_flags[w_sel];
    assign o_first = w_first;

    `SBRC_ASSERT_SAME(a_total_matches_flags, i_clk, i_rst_n, 1'b1, $countones(r_flags) == int'(r_total))
    `SBRC_ASSERT_SAME(a_set_clr_exclusive, i_clk, i_rst_n, i_ctl.set, !i_ctl.clr)
    `SBRC_ASSERT_NEXT(a_set_marks_flag, i_clk, i_rst_n, i_ctl.set, r_flags[$past(w_idx)])

endmodule

`default_nettype wire

// ===== rtl/shared_buffer_refcount_conflict_tracker_unit.sv =====
// top level of the shared buffer refcount conflict tracker
//
// i_in takes one delta item (net, owner, removed and added uses) on valid and ready.
// o_out gives exactly one result item per input item, in order, on valid and ready.
// i_cfg_we with i_cfg_idx and i_cfg_data writes nets_in_use or owners_in_use.
// each item goes through these steps: the accept edge issues the memory reads, the
// update step checks and writes back pair and owner counts and updates the conflict flags,
// the report step loads the output register, and o_out.valid rises when that register is loaded.
// the next item is accepted in the cycle after its result is loaded, so the block takes no
// new item before it is through with the last, set by the read, modify and write of the memories.
// a stalled receiver holds the result in the output register; the block then
// waits in its report step and takes no new item until the register frees.
// after reset a clearing pass zeroes the pair memory and the owner net counts, one entry per
// cycle, over all MAX_NETS * MAX_OWNERS entries (4096 by default); i_in.ready stays low until done.
// configuration writes are taken at any time, also during the clearing pass.
`default_nettype none
`include "shared_buffer_refcount_conflict_tracker_unit_assert.svh"

module shared_buffer_refcount_conflict_tracker_unit #(
    parameter int MAX_NETS   = 64,
    parameter int MAX_OWNERS = 64,
    parameter int COUNT_BITS = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [sbrc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [sbrc_pkg::CFG_W-1:0]       i_cfg_data,
    sbrc_in_if.sink                         i_in,
    sbrc_out_if.source                      o_out
);

    localparam int OW  = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
    localparam int CNW = $clog2(MAX_NETS + 1);
    localparam int TW  = $clog2(MAX_OWNERS + 1);
    localparam int W   = ((COUNT_BITS > sbrc_pkg::USES_W) ? COUNT_BITS : sbrc_pkg::USES_W) + 1;

    localparam logic [W-1:0] CMAX = W'({COUNT_BITS{1'b1}});

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_UPDATE = 3'b010,
        S_REPORT = 3'b100
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic [sbrc_pkg::CFG_W-1:0]   r_nets_in_use;
    logic [sbrc_pkg::CFG_W-1:0]   r_owners_in_use;
    sbrc_pkg::t_in_item           r_item;
    sbrc_pkg::t_status            r_res_status;
    logic [sbrc_pkg::PAIR_OUT_W-1:0] r_res_pair;
    logic [sbrc_pkg::CNT_OUT_W-1:0]  r_res_cnt;
    logic                         r_res_show;
    logic                         r_out_valid;
    sbrc_pkg::t_out_item          r_out_data;

    sbrc_pkg::t_store_ctl         w_store_ctl;
    sbrc_pkg::t_flag_ctl          w_flag_ctl;
    sbrc_pkg::t_status            w_status;
    logic [COUNT_BITS-1:0]        w_pair_rdata;
    logic [CNW-1:0]               w_cnt_rdata;
    logic [CNW-1:0]               w_oc_new;
    logic [TW-1:0]                w_total;
    logic [OW-1:0]                w_first;
    logic [W-1:0]                 w_cur;
    logic [W-1:0]                 w_rem;
    logic [W-1:0]                 w_add;
    logic [W-1:0]                 w_next;
    logic [W-1:0]                 w_pair_val;
    logic                         w_busy;
    logic                         w_flag;
    logic                         w_accept;
    logic                         w_load;
    logic                         w_net_err;
    logic                         w_owner_err;
    logic                         w_apply;
    logic                         w_show;
    logic                         w_become;
    logic                         w_leave;

    assign i_in.ready = (r_state == S_IDLE) && !w_busy;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load     = (r_state == S_REPORT) && (!r_out_valid || o_out.ready);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nets_in_use   <= sbrc_pkg::CFG_RESET;
            r_owners_in_use <= sbrc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (sbrc_pkg::t_cfg_idx'(i_cfg_idx))
                sbrc_pkg::CFG_NETS_IN_USE:   r_nets_in_use   <= i_cfg_data;
                sbrc_pkg::CFG_OWNERS_IN_USE: r_owners_in_use <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = S_REPORT;
            end
            S_REPORT: begin
                if (w_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in.data;
        end
    end

    // checks and count arithmetic on the read data
    assign w_net_err   = ({1'b0, r_item.net_index} >= r_nets_in_use)
                         || (int'(r_item.net_index) >= MAX_NETS);
    assign w_owner_err = ({1'b0, r_item.owner_index} >= r_owners_in_use)
                         || (int'(r_item.owner_index) >= MAX_OWNERS);
    assign w_cur  = W'(w_pair_rdata);
    assign w_rem  = W'(r_item.removed_uses);
    assign w_add  = W'(r_item.added_uses);
    assign w_next = w_cur - w_rem + w_add;

    always_comb begin
        w_status = sbrc_pkg::ST_OK;
        w_apply  = 1'b0;
        w_show   = 1'b0;
        if (w_net_err) begin
            w_status = sbrc_pkg::ST_RANGE;
        end else if (r_item.owner_present) begin
            if (w_owner_err) begin
                w_status = sbrc_pkg::ST_RANGE;
            end else if (w_rem > w_cur) begin
                w_status = sbrc_pkg::ST_UNDERFLOW;
                w_show   = 1'b1;
            end else if (w_next > CMAX) begin
                w_status = sbrc_pkg::ST_OVERFLOW;
                w_show   = 1'b1;
            end else begin
                w_apply  = 1'b1;
                w_show   = 1'b1;
            end
        end
    end

    assign w_become = (w_cur == '0) && (w_next != '0);
    assign w_leave  = (w_cur != '0) && (w_next == '0) && (w_cnt_rdata != '0);

    always_comb begin
        w_oc_new = w_cnt_rdata;
        if (w_apply && w_become) begin
            w_oc_new = w_cnt_rdata + 1'b1;
        end else if (w_apply && w_leave) begin
            w_oc_new = w_cnt_rdata - 1'b1;
        end
    end

    assign w_pair_val = w_apply ? w_next : w_cur;

    assign w_store_ctl.rd_en = w_accept;
    assign w_store_ctl.wr_en = (r_state == S_UPDATE) && w_apply;
    assign w_store_ctl.net   = w_accept ? i_in.data.net_index : r_item.net_index;
    assign w_store_ctl.owner = w_accept ? i_in.data.owner_index : r_item.owner_index;

    assign w_flag_ctl.set   = (r_state == S_UPDATE) && w_apply && w_become
                              && (int'(w_oc_new) == 2);
    assign w_flag_ctl.clr   = (r_state == S_UPDATE) && w_apply && w_leave
                              && (int'(w_oc_new) == 1);
    assign w_flag_ctl.owner = r_item.owner_index;

    sbrc_store #(
        .MAX_NETS   (MAX_NETS),
        .MAX_OWNERS (MAX_OWNERS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_store_ctl),
        .i_pair_wdata (w_next[COUNT_BITS-1:0]),
        .i_cnt_wdata  (w_oc_new),
        .o_pair_rdata (w_pair_rdata),
        .o_cnt_rdata  (w_cnt_rdata),
        .o_busy       (w_busy)
    );

    sbrc_conflict #(
        .MAX_OWNERS (MAX_OWNERS)
    ) u_conflict (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_flag_ctl),
        .i_sel_owner (r_item.owner_index),
        .o_total     (w_total),
        .o_flag      (w_flag),
        .o_first     (w_first)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_res_status <= w_status;
            r_res_show   <= w_show;
            r_res_pair   <= w_show ? sbrc_pkg::PAIR_OUT_W'(w_pair_val) : '0;
            r_res_cnt    <= w_show ? sbrc_pkg::CNT_OUT_W'(w_oc_new) : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data.status               <= r_res_status;
            r_out_data.pair_refcount        <= r_res_pair;
            r_out_data.owner_net_count      <= r_res_cnt;
            r_out_data.owner_in_conflict    <= r_res_show && w_flag;
            r_out_data.conflict_total       <= sbrc_pkg::CNT_OUT_W'(w_total);
            r_out_data.any_conflict         <= (w_total != '0);
            r_out_data.first_conflict_owner <= sbrc_pkg::OWNER_W'(w_first);
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    `SBRC_ASSERT_NEXT(a_accept_to_update, i_clk, i_rst_n, w_accept, r_state == S_UPDATE)
    `SBRC_ASSERT_NEXT(a_update_to_report, i_clk, i_rst_n, r_state == S_UPDATE, r_state == S_REPORT)
    `SBRC_ASSERT_SAME(a_result_after_report, i_clk, i_rst_n, $rose(o_out.valid), $past(r_state == S_REPORT))

endmodule

`default_nettype wire

// ===== tb/tb_shared_buffer_refcount_conflict_tracker_unit.sv =====
// testbench for the refcount conflict tracker: directed table, then random deltas checked in order
`timescale 1ns / 1ps

module tb_shared_buffer_refcount_conflict_tracker_unit;

    localparam int NET_SPAN   = 64;
    localparam int OWNER_SPAN = 64;
    localparam int USE_MAX    = 65535;
    localparam int IDLE_PAD   = 8;
    localparam int UNDO_DEPTH = 32;
    localparam int TIMEOUT_NS = 1000000;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind                  kind;
        sbrc_pkg::t_cfg_idx         cfg_sel;
        logic [sbrc_pkg::CFG_W-1:0] cfg_val;
        sbrc_pkg::t_in_item         item;
        bit                         typed;
        sbrc_pkg::t_out_item        res;
    } t_row;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [sbrc_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [sbrc_pkg::CFG_W-1:0]     cfg_data;

    sbrc_in_if  in_ch();
    sbrc_out_if out_ch();

    shared_buffer_refcount_conflict_tracker_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // tracker state as the block should hold it
    logic [sbrc_pkg::USES_W-1:0]    pair_use [NET_SPAN*OWNER_SPAN];
    logic [sbrc_pkg::CNT_OUT_W-1:0] owner_users [OWNER_SPAN];
    logic [63:0]                    conflict_mask;
    logic [sbrc_pkg::CNT_OUT_W-1:0] conflict_count;
    logic [sbrc_pkg::CFG_W-1:0]     nets_limit;
    logic [sbrc_pkg::CFG_W-1:0]     owners_limit;

    sbrc_pkg::t_out_item pending_results[$];
    sbrc_pkg::t_in_item  undo_log[$];
    t_row                directed_rows[$];
    sbrc_pkg::t_out_item want_result;
    int                  mismatch_count = 0;
    bit                  calm = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    function automatic sbrc_pkg::t_out_item track_delta(sbrc_pkg::t_in_item it);
        sbrc_pkg::t_out_item r;
        int        slot;
        int        cur;
        int        nxt;
        int        oc;
        int        net_lim;
        int        own_lim;
        int        i;
        r = '0;
        r.status = sbrc_pkg::ST_OK;
        net_lim = (int'(nets_limit) > NET_SPAN) ? NET_SPAN : int'(nets_limit);
        own_lim = (int'(owners_limit) > OWNER_SPAN) ? OWNER_SPAN : int'(owners_limit);
        if (int'(it.net_index) >= net_lim) begin
            r.status = sbrc_pkg::ST_RANGE;
        end else if (it.owner_present && int'(it.owner_index) >= own_lim) begin
            r.status = sbrc_pkg::ST_RANGE;
        end else if (it.owner_present) begin
            slot = int'(it.net_index) * OWNER_SPAN + int'(it.owner_index);
            cur = int'(pair_use[slot]);
            if (int'(it.removed_uses) > cur) begin
                r.status = sbrc_pkg::ST_UNDERFLOW;
            end else if (cur - int'(it.removed_uses) + int'(it.added_uses) > USE_MAX) begin
                r.status = sbrc_pkg::ST_OVERFLOW;
            end else begin
                nxt = cur - int'(it.removed_uses) + int'(it.added_uses);
                oc = int'(owner_users[it.owner_index]);
                if (cur == 0 && nxt != 0) begin
                    oc++;
                    if (oc == 2) begin
                        conflict_count = conflict_count + 1'b1;
                        conflict_mask[it.owner_index] = 1'b1;
                    end
                end else if (cur != 0 && nxt == 0 && oc != 0) begin
                    oc--;
                    if (oc == 1 && conflict_count != 0) begin
                        conflict_count = conflict_count - 1'b1;
                        conflict_mask[it.owner_index] = 1'b0;
                    end
                end
                owner_users[it.owner_index] = sbrc_pkg::CNT_OUT_W'(oc);
                pair_use[slot] = sbrc_pkg::USES_W'(nxt);
            end
            r.pair_refcount = pair_use[slot];
            r.owner_net_count = owner_users[it.owner_index];
            r.owner_in_conflict = conflict_mask[it.owner_index];
        end
        r.conflict_total = conflict_count;
        r.any_conflict = (conflict_count != 0);
        for (i = 63; i >= 0; i--) begin
            if (conflict_mask[i]) begin
                r.first_conflict_owner = sbrc_pkg::OWNER_W'(i);
            end
        end
        return r;
    endfunction

    function automatic sbrc_pkg::t_in_item delta(int net, int pres, int own, int rem, int add);
        sbrc_pkg::t_in_item d;
        d.net_index = sbrc_pkg::NET_W'(net);
        d.owner_present = (pres != 0);
        d.owner_index = sbrc_pkg::OWNER_W'(own);
        d.removed_uses = sbrc_pkg::USES_W'(rem);
        d.added_uses = sbrc_pkg::USES_W'(add);
        return d;
    endfunction

    function automatic sbrc_pkg::t_out_item result(sbrc_pkg::t_status st, int pair, int cnt,
                                                   int conf, int total, int any, int first);
        sbrc_pkg::t_out_item r;
        r.status = st;
        r.pair_refcount = sbrc_pkg::PAIR_OUT_W'(pair);
        r.owner_net_count = sbrc_pkg::CNT_OUT_W'(cnt);
        r.owner_in_conflict = (conf != 0);
        r.conflict_total = sbrc_pkg::CNT_OUT_W'(total);
        r.any_conflict = (any != 0);
        r.first_conflict_owner = sbrc_pkg::OWNER_W'(first);
        return r;
    endfunction

    function automatic t_row item_row(sbrc_pkg::t_in_item it, bit typed,
                                      sbrc_pkg::t_out_item res);
        t_row r;
        r.kind = ROW_ITEM;
        r.cfg_sel = sbrc_pkg::CFG_NETS_IN_USE;
        r.cfg_val = '0;
        r.item = it;
        r.typed = typed;
        r.res = res;
        return r;
    endfunction

    function automatic t_row cfg_row(sbrc_pkg::t_cfg_idx sel, int val);
        t_row r;
        r.kind = ROW_CFG;
        r.cfg_sel = sel;
        r.cfg_val = sbrc_pkg::CFG_W'(val);
        r.item = '0;
        r.typed = 1'b0;
        r.res = '0;
        return r;
    endfunction

    function automatic void add_row(t_row r);
        directed_rows = {directed_rows, r};
    endfunction

    function automatic sbrc_pkg::t_in_item random_item();
        sbrc_pkg::t_in_item it;
        sbrc_pkg::t_in_item h;
        logic [63:0] raw;
        int          pick;
        int          n;
        int          o;
        int          cur;
        int          rem;
        int          add;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            raw = {$urandom(), $urandom()};
            it = raw[$bits(sbrc_pkg::t_in_item)-1:0];
        end else if (pick < 22 && undo_log.size() != 0) begin
            // revert: same item with the counts swapped
            h = undo_log[$urandom_range(0, undo_log.size() - 1)];
            it = h;
            it.removed_uses = h.added_uses;
            it.added_uses = h.removed_uses;
        end else begin
            n = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 63);
            o = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 63);
            cur = int'(pair_use[n * OWNER_SPAN + o]);
            case ($urandom_range(0, 2))
                0: rem = 0;
                1: rem = cur;
                default: rem = $urandom_range(0, cur);
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                add = 0;
            end else if (pick < 8) begin
                add = $urandom_range(1, 15);
            end else begin
                add = $urandom_range(0, USE_MAX);
            end
            it = delta(n, ($urandom_range(0, 99) < 95) ? 1 : 0, o, rem, add);
        end
        return it;
    endfunction

    task automatic issue(sbrc_pkg::t_in_item it, bit typed, sbrc_pkg::t_out_item typed_res);
        sbrc_pkg::t_out_item predicted;
        predicted = track_delta(it);
        pending_results = {pending_results, (typed ? typed_res : predicted)};
        if (it.owner_present && predicted.status == sbrc_pkg::ST_OK) begin
            undo_log = {undo_log, it};
            if (undo_log.size() > UNDO_DEPTH) begin
                void'(undo_log.pop_front());
            end
        end
        while (!calm && $urandom_range(0, 99) < 20) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    task automatic write_cfg(sbrc_pkg::t_cfg_idx sel, logic [sbrc_pkg::CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= sel;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == sbrc_pkg::CFG_NETS_IN_USE) begin
            nets_limit = val;
        end else begin
            owners_limit = val;
        end
        @(posedge clk);
    endtask

    task automatic fill_owner(int o);
        int n;
        for (n = 0; n < NET_SPAN; n++) begin
            issue(delta(n, 1, o, 0, 1), 1'b0, '0);
        end
        for (n = 0; n < NET_SPAN; n += 2) begin
            issue(delta(n, 1, o, 1, 0), 1'b0, '0);
        end
    endtask

    task automatic fill_conflicts();
        int o;
        for (o = 0; o < OWNER_SPAN; o++) begin
            issue(delta(62, 1, o, 0, 1), 1'b0, '0);
            issue(delta(63, 1, o, 0, 1), 1'b0, '0);
        end
        for (o = 0; o < OWNER_SPAN; o++) begin
            issue(delta(63, 1, o, 1, 0), 1'b0, '0);
        end
    endtask

    // result side: check in order, then pick the next ready
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected item, actual status %0d pair %0d", $time,
                             out_ch.data.status, out_ch.data.pair_refcount);
                    mismatch_count++;
                end else begin
                    want_result = pending_results.pop_front();
                    if (out_ch.data !== want_result) begin
                        $display("%0t: status/pair/nets/conflict/total/any/first", $time,
                                 " expected %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                                 want_result.status, want_result.pair_refcount,
                                 want_result.owner_net_count, want_result.owner_in_conflict,
                                 want_result.conflict_total, want_result.any_conflict,
                                 want_result.first_conflict_owner,
                                 " actual %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                                 out_ch.data.status, out_ch.data.pair_refcount,
                                 out_ch.data.owner_net_count, out_ch.data.owner_in_conflict,
                                 out_ch.data.conflict_total, out_ch.data.any_conflict,
                                 out_ch.data.first_conflict_owner);
                        mismatch_count++;
                    end
                end
            end
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    initial begin
        int p;
        int k;
        int i;
        int span;
        int nets_val;
        int owners_val;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= sbrc_pkg::CFG_NETS_IN_USE;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        for (i = 0; i < NET_SPAN * OWNER_SPAN; i++) begin
            pair_use[i] = '0;
        end
        for (i = 0; i < OWNER_SPAN; i++) begin
            owner_users[i] = '0;
        end
        conflict_mask = '0;
        conflict_count = '0;
        nets_limit = sbrc_pkg::CFG_RESET;
        owners_limit = sbrc_pkg::CFG_RESET;

        add_row(item_row(delta(0, 1, 0, 0, 0), 1, result(sbrc_pkg::ST_OK, 0, 0, 0, 0, 0, 0)));
        add_row(item_row(delta(0, 1, 0, 1, 0), 1,
                         result(sbrc_pkg::ST_UNDERFLOW, 0, 0, 0, 0, 0, 0)));
        add_row(item_row(delta(0, 1, 0, 0, USE_MAX), 1,
                         result(sbrc_pkg::ST_OK, USE_MAX, 1, 0, 0, 0, 0)));
        add_row(item_row(delta(0, 1, 0, 0, 1), 1,
                         result(sbrc_pkg::ST_OVERFLOW, USE_MAX, 1, 0, 0, 0, 0)));
        add_row(item_row(delta(63, 1, 0, 0, 5), 1,
                         result(sbrc_pkg::ST_OK, 5, 2, 1, 1, 1, 0)));
        add_row(item_row(delta(63, 1, 63, 0, 7), 1,
                         result(sbrc_pkg::ST_OK, 7, 1, 0, 1, 1, 0)));
        add_row(item_row(delta(1, 1, 63, 0, 1), 1,
                         result(sbrc_pkg::ST_OK, 1, 2, 1, 2, 1, 0)));
        add_row(item_row(delta(5, 0, 63, USE_MAX, USE_MAX), 1,
                         result(sbrc_pkg::ST_OK, 0, 0, 0, 2, 1, 0)));
        add_row(item_row(delta(63, 1, 0, 5, 0), 1,
                         result(sbrc_pkg::ST_OK, 0, 1, 0, 1, 1, 63)));
        add_row(item_row(delta(0, 1, 0, USE_MAX, USE_MAX), 0, '0));
        add_row(item_row(delta(0, 1, 0, USE_MAX, 0), 0, '0));
        add_row(cfg_row(sbrc_pkg::CFG_NETS_IN_USE, 10));
        add_row(cfg_row(sbrc_pkg::CFG_OWNERS_IN_USE, 5));
        add_row(item_row(delta(10, 1, 0, 0, 0), 1,
                         result(sbrc_pkg::ST_RANGE, 0, 0, 0, 1, 1, 63)));
        add_row(item_row(delta(9, 1, 5, 0, 3), 1,
                         result(sbrc_pkg::ST_RANGE, 0, 0, 0, 1, 1, 63)));
        add_row(item_row(delta(9, 0, 5, 0, 3), 1,
                         result(sbrc_pkg::ST_OK, 0, 0, 0, 1, 1, 63)));
        add_row(item_row(delta(63, 0, 0, 0, 0), 1,
                         result(sbrc_pkg::ST_RANGE, 0, 0, 0, 1, 1, 63)));
        add_row(item_row(delta(9, 1, 4, 0, 2), 0, '0));
        add_row(cfg_row(sbrc_pkg::CFG_NETS_IN_USE, 0));
        add_row(item_row(delta(0, 0, 0, 0, 0), 1,
                         result(sbrc_pkg::ST_RANGE, 0, 0, 0, 1, 1, 63)));
        add_row(cfg_row(sbrc_pkg::CFG_NETS_IN_USE, 64));
        add_row(cfg_row(sbrc_pkg::CFG_OWNERS_IN_USE, 0));
        add_row(item_row(delta(5, 1, 0, 0, 1), 1,
                         result(sbrc_pkg::ST_RANGE, 0, 0, 0, 1, 1, 63)));
        add_row(item_row(delta(5, 0, 0, 0, 1), 1,
                         result(sbrc_pkg::ST_OK, 0, 0, 0, 1, 1, 63)));
        add_row(cfg_row(sbrc_pkg::CFG_NETS_IN_USE, 127));
        add_row(cfg_row(sbrc_pkg::CFG_OWNERS_IN_USE, 127));
        add_row(item_row(delta(63, 1, 63, 7, 0), 1,
                         result(sbrc_pkg::ST_OK, 0, 1, 0, 0, 0, 0)));
        add_row(item_row(delta(63, 1, 63, 0, USE_MAX), 0, '0));
        add_row(item_row(delta(1, 1, 63, 0, USE_MAX), 0, '0));
        add_row(item_row(delta(63, 1, 63, USE_MAX, 0), 0, '0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[j]) begin
            if (directed_rows[j].kind == ROW_CFG) begin
                drain();
                write_cfg(directed_rows[j].cfg_sel, directed_rows[j].cfg_val);
            end else begin
                issue(directed_rows[j].item, directed_rows[j].typed, directed_rows[j].res);
            end
        end

        for (p = 0; p < 5; p++) begin
            case (p)
                0: begin
                    nets_val = 64;
                    owners_val = 64;
                    span = 250;
                end
                1: begin
                    nets_val = 16;
                    owners_val = 8;
                    span = 150;
                end
                2: begin
                    nets_val = 127;
                    owners_val = 127;
                    span = 200;
                end
                3: begin
                    nets_val = 3;
                    owners_val = 2;
                    span = 80;
                end
                default: begin
                    nets_val = $urandom_range(0, 127);
                    owners_val = $urandom_range(0, 127);
                    span = 120;
                end
            endcase
            drain();
            write_cfg(sbrc_pkg::CFG_NETS_IN_USE, sbrc_pkg::CFG_W'(nets_val));
            write_cfg(sbrc_pkg::CFG_OWNERS_IN_USE, sbrc_pkg::CFG_W'(owners_val));
            calm = (p == 2);
            if (p == 0) begin
                fill_owner($urandom_range(0, 63));
            end
            if (p == 2) begin
                fill_conflicts();
            end
            for (k = 0; k < span; k++) begin
                if (k == span / 2) begin
                    drain();
                end
                issue(random_item(), 1'b0, '0);
            end
        end
        calm = 1'b0;

        drain();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sbrc_pkg.sv
rtl/sbrc_if.sv
rtl/sbrc_store.sv
rtl/sbrc_conflict.sv
rtl/shared_buffer_refcount_conflict_tracker_unit.sv
tb/tb_shared_buffer_refcount_conflict_tracker_unit.sv
